// ----- rtl/core/lpfp_pkg.sv -----
// Shared types and constants for the length-prefixed frame parser.
// No dependencies; imported by lpfp_core and length_prefixed_frame_parser.
package lpfp_pkg;

	// Width of the internal length counters; the reported length saturates to it (max 32).
	localparam int COUNT_WIDTH = 32;
	localparam int SAT_WIDTH   = (COUNT_WIDTH > 32) ? 32 : COUNT_WIDTH;
	localparam logic [63:0] SAT_CAP = (64'd1 << SAT_WIDTH) - 64'd1;

	localparam logic [31:0] MAX_LEN_RESET = 32'd16384;
	localparam logic [63:0] ESCAPE_LEN    = 64'h0000_0000_0000_FFFF;

	// Header field sizes in bytes
	localparam logic [31:0] LEN_BYTES   = 32'd2;
	localparam logic [31:0] EXLEN_BYTES = 32'd8;
	localparam logic [31:0] ID_BYTES    = 32'd2;

	localparam logic [2:0] LEN_LAST_IDX   = 3'(LEN_BYTES - 32'd1);
	localparam logic [2:0] EXLEN_LAST_IDX = 3'(EXLEN_BYTES - 32'd1);
	localparam logic [2:0] ID_LAST_IDX    = 3'(ID_BYTES - 32'd1);

	typedef enum logic [3:0] {
		PH_LEN   = 4'b0001,
		PH_EXLEN = 4'b0010,
		PH_ID    = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER    = 2'd0,
		KIND_PAYLOAD   = 2'd1,
		KIND_EMPTY     = 2'd2,
		KIND_TOO_LARGE = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] message_id;
		logic        last;
		logic [31:0] payload_length;
	} result_t;

	typedef struct packed {
		logic   halted;
		phase_t phase;
	} core_status_t;

endpackage

// ----- rtl/core/lpfp_core.sv -----
// Frame state and per-byte parse step of the length-prefixed frame parser.
// Depends on lpfp_pkg.
module lpfp_core import lpfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   rx_byte,
	input  logic [31:0]  max_len,
	output result_t      result,
	output core_status_t status
);

	phase_t      phase_q, phase_n;
	logic [2:0]  idx_q, idx_n;
	logic [63:0] len_q, len_n;
	logic [15:0] id_q, id_n;
	logic [32:0] fcount_q, fcount_n;
	logic [31:0] rem_q, rem_n;
	logic        halted_q, halted_n;

	logic [32:0] count;
	logic        done;
	logic        expect_big;
	logic [63:0] len_new;
	logic [15:0] id_new;
	logic        next_big;
	logic [63:0] len_out;

	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		len_n    = len_q;
		id_n     = id_q;
		fcount_n = fcount_q;
		rem_n    = rem_q;
		halted_n = halted_q;

		result.kind       = KIND_HEADER;
		result.data       = 8'd0;
		result.message_id = id_q;
		result.last       = 1'b0;
		len_out           = len_q;

		count    = fcount_q + 33'd1;
		id_new   = (idx_q == 3'd0) ? {8'd0, rx_byte} : {rx_byte, id_q[7:0]};
		len_new  = (idx_q == 3'd0) ? 64'd0 : len_q;
		for (int lane = 0; lane < 8; lane++) begin
			if (idx_q == 3'(lane))
				len_new[lane*8 +: 8] = rx_byte;
		end
		next_big = 1'b0;

		unique case (phase_q)
			PH_DATA: begin
				done       = (rem_q == 32'd1);
				expect_big = (len_q > {32'd0, max_len});
			end
			PH_EXLEN: begin
				done       = (idx_q == EXLEN_LAST_IDX);
				expect_big = (EXLEN_BYTES > max_len);
			end
			PH_ID: begin
				done       = (idx_q == ID_LAST_IDX);
				expect_big = (ID_BYTES > max_len);
			end
			default: begin
				done       = (idx_q == LEN_LAST_IDX);
				expect_big = (LEN_BYTES > max_len);
			end
		endcase

		if (halted_q) begin
			result.kind = KIND_TOO_LARGE;
		end else if ((!done && expect_big) || (count > {1'b0, max_len})) begin
			halted_n    = 1'b1;
			result.kind = KIND_TOO_LARGE;
		end else begin
			fcount_n = count;
			unique case (phase_q) inside
				PH_DATA: begin
					rem_n        = rem_q - 32'd1;
					result.kind  = KIND_PAYLOAD;
					result.data  = rx_byte;
					if (done) begin
						result.last = 1'b1;
						phase_n     = PH_LEN;
						idx_n       = 3'd0;
						len_n       = 64'd0;
						id_n        = 16'd0;
						fcount_n    = 33'd0;
						rem_n       = 32'd0;
					end
				end
				PH_ID: begin
					id_n              = id_new;
					result.message_id = id_new;
					if (!done) begin
						idx_n = idx_q + 3'd1;
					end else if (len_q == 64'd0) begin
						// empty message: report and restart at the length field
						result.kind = KIND_EMPTY;
						result.last = 1'b1;
						phase_n     = PH_LEN;
						idx_n       = 3'd0;
						len_n       = 64'd0;
						id_n        = 16'd0;
						fcount_n    = 33'd0;
						rem_n       = 32'd0;
					end else begin
						idx_n = 3'd0;
						if (len_q > {32'd0, max_len}) begin
							halted_n    = 1'b1;
							result.kind = KIND_TOO_LARGE;
						end else begin
							phase_n = PH_DATA;
							rem_n   = len_q[31:0];
						end
					end
				end
				PH_LEN, PH_EXLEN: begin
					len_n   = len_new;
					len_out = len_new;
					if (!done) begin
						idx_n = idx_q + 3'd1;
					end else begin
						idx_n = 3'd0;
						if (phase_q == PH_LEN && len_new == ESCAPE_LEN) begin
							phase_n  = PH_EXLEN;
							next_big = (EXLEN_BYTES > max_len);
						end else begin
							phase_n  = PH_ID;
							next_big = (ID_BYTES > max_len);
						end
						if (next_big) begin
							halted_n    = 1'b1;
							result.kind = KIND_TOO_LARGE;
						end
					end
				end
				default: begin
					halted_n    = 1'b1;
					result.kind = KIND_TOO_LARGE;
				end
			endcase
		end

		result.payload_length = (len_out > SAT_CAP) ? SAT_CAP[31:0] : len_out[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_LEN;
			idx_q    <= 3'd0;
			len_q    <= 64'd0;
			id_q     <= 16'd0;
			fcount_q <= 33'd0;
			rem_q    <= 32'd0;
			halted_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			len_q    <= len_n;
			id_q     <= id_n;
			fcount_q <= fcount_n;
			rem_q    <= rem_n;
			halted_q <= halted_n;
		end
	end

	assign status.halted = halted_q;
	assign status.phase  = phase_q;

endmodule

// ----- rtl/core/length_prefixed_frame_parser.sv -----
// Top level of the length-prefixed frame parser: input register, result register,
// configuration register and checks. Depends on lpfp_pkg and lpfp_core.
//
// Takes one received byte per item and returns exactly one result item per byte,
// sustaining one item per clock unless out_stall holds the result register; each
// byte passes the input register, the parse step, then the result register. A frame is
// a 2-byte little-endian length (0xFFFF escapes to an 8-byte length), a 2-byte
// little-endian message id, then the payload. Header bytes report kind 0, payload
// bytes kind 1 with last on the final byte, a zero-length payload kind 2 with last
// set on its final id byte. When a frame or an announced length exceeds
// max_request_length (header included) the item reports kind 3 and every later item
// does too, until reset. max_request_length resets to 16384 and is written through
// cfg_valid/cfg_ready only while the block is idle: the user is bound to this, the
// block does not enforce it. cfg_ready is always high. No clearing pass follows reset.
module length_prefixed_frame_parser import lpfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// byte input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data,
	output logic [15:0] message_id,
	output logic        last,
	output logic [31:0] payload_length,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] max_request_length
);

	logic [31:0]  max_len_q;
	logic [7:0]   byte_s1;
	logic         valid_s1;
	result_t      result_s2;
	logic         valid_s2;
	logic         step;
	logic         accept_in;
	result_t      step_result;
	core_status_t status;

	// Advance the input item whenever the result register is empty or being drained.
	assign step      = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall  = valid_s1 && !step;
	assign accept_in = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= max_request_length;
		end
	end

	// Input register: hold the byte until the parse step takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept_in || (valid_s1 && !step);
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in)
			byte_s1 <= rx_byte;
	end

	lpfp_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.max_len (max_len_q),
		.result  (step_result),
		.status  (status)
	);

	// Result register: hold a stalled result, load a new one on each step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= step || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			result_s2 <= step_result;
	end

	assign out_valid      = valid_s2;
	assign kind           = result_s2.kind;
	assign data           = result_s2.data;
	assign message_id     = result_s2.message_id;
	assign last           = result_s2.last;
	assign payload_length = result_s2.payload_length;

	// The error state never clears short of reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |=> status.halted)
		else $error("error state cleared without reset");

	// A too-large result leaves the parser halted.
	a_halt_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		step && step_result.kind == KIND_TOO_LARGE |=> status.halted)
		else $error("too-large result without halt");

	// A message end restarts parsing at the length field.
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && step_result.last |=> status.phase == PH_LEN)
		else $error("frame did not restart after last");

	// The input side only stalls while a finished result is held.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall && valid_s1))
		else $error("input stalled without a held result");

endmodule

// ----- tb/sv/tb_length_prefixed_frame_parser.sv -----
// Self-checking testbench for length_prefixed_frame_parser: streams framed bytes,
// predicts one result item per byte and checks every field against the block.
// Depends on lpfp_pkg and length_prefixed_frame_parser.
`timescale 1ns / 1ps

module tb_length_prefixed_frame_parser;
	import lpfp_pkg::*;

	// ways to push the parser into its sticky too-large state at the end of the run
	typedef enum int {
		ERR_ANY_BYTE,
		ERR_ANNOUNCED,
		ERR_EXTENDED,
		ERR_RUNNING,
		ERR_FIELD
	} overflow_case_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data;
	logic [15:0] message_id;
	logic        last;
	logic [31:0] payload_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] max_request_length = 32'd0;

	length_prefixed_frame_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.data(data),
		.message_id(message_id),
		.last(last),
		.payload_length(payload_length),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.max_request_length(max_request_length)
	);

	always #4 clk = ~clk;

	// Bytes waiting to be offered, and the results they are predicted to cause,
	// oldest first.
	logic [7:0] pending_bytes[$];
	result_t    expected_results[$];

	// Pace of both sides, in percent of cycles spent idle or stalling.
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned idle_pcts[4] = '{0, 76, 0, 27};
	int unsigned stall_pcts[4] = '{0, 0, 76, 27};

	int unsigned error_count = 0;
	int unsigned bytes_queued = 0;
	int unsigned bytes_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned frames_queued = 0;
	int unsigned limits_written = 0;
	int unsigned kind_count[4] = '{0, 0, 0, 0};

	// Parser state as the predictor sees it.
	phase_t      parse_phase;
	logic [2:0]  field_idx;
	logic [63:0] announced_len;
	logic [15:0] frame_id;
	logic [32:0] frame_bytes;
	logic [31:0] payload_left;
	logic        parser_halted;
	logic [31:0] max_len_cfg;

	// Drop the frame state and go back to waiting for a length field.
	function automatic void clear_frame();
		parse_phase   = PH_LEN;
		field_idx     = 3'd0;
		announced_len = 64'd0;
		frame_id      = 16'd0;
		frame_bytes   = 33'd0;
		payload_left  = 32'd0;
	endfunction

	// Build one result item; the reported length saturates at the counter width.
	function automatic result_t form_result(input kind_t k, input logic [7:0] d,
			input logic [15:0] id, input logic l, input logic [63:0] len);
		result_t     r;
		logic [63:0] capped;
		capped           = (len > SAT_CAP) ? SAT_CAP : len;
		r.kind           = k;
		r.data           = d;
		r.message_id     = id;
		r.last           = l;
		r.payload_length = capped[31:0];
		return r;
	endfunction

	// Latch the sticky error; id and length stay as they stand.
	function automatic result_t halt_parse();
		parser_halted = 1'b1;
		return form_result(KIND_TOO_LARGE, 8'd0, frame_id, 1'b0, announced_len);
	endfunction

	// Advance the predicted parser by one received byte and return its result.
	function automatic result_t parse_byte(input logic [7:0] b);
		result_t     r;
		logic [63:0] need;
		logic [63:0] got;
		logic [63:0] count;
		logic [63:0] next_need;
		logic        done;
		if (parser_halted)
			return halt_parse();
		count = 64'(frame_bytes) + 64'd1;
		// bytes the current field wants in all, and how many it has after this one
		if (parse_phase == PH_DATA) begin
			need = announced_len;
			got  = announced_len - 64'(payload_left) + 64'd1;
		end else begin
			need = (parse_phase == PH_EXLEN) ? 64'(EXLEN_BYTES) : 64'(LEN_BYTES);
			got  = 64'(field_idx) + 64'd1;
		end
		done = (got >= need);
		if ((!done && need > 64'(max_len_cfg)) || count > 64'(max_len_cfg))
			return halt_parse();
		frame_bytes = count[32:0];
		case (parse_phase)
			PH_DATA: begin
				payload_left = payload_left - 32'd1;
				r = form_result(KIND_PAYLOAD, b, frame_id, payload_left == 32'd0,
					announced_len);
				if (payload_left == 32'd0)
					clear_frame();
				return r;
			end
			PH_ID: begin
				if (field_idx == 3'd0)
					frame_id = {8'd0, b};
				else
					frame_id = frame_id | {b, 8'd0};
				if (!done) begin
					field_idx = field_idx + 3'd1;
				end else if (announced_len == 64'd0) begin
					r = form_result(KIND_EMPTY, 8'd0, frame_id, 1'b1, 64'd0);
					clear_frame();
					return r;
				end else begin
					field_idx = 3'd0;
					if (announced_len > 64'(max_len_cfg))
						return halt_parse();
					parse_phase  = PH_DATA;
					payload_left = announced_len[31:0];
				end
			end
			default: begin
				// short or extended length field, little-endian
				if (field_idx == 3'd0)
					announced_len = 64'd0;
				announced_len = announced_len | (64'(b) << (8 * field_idx));
				if (!done) begin
					field_idx = field_idx + 3'd1;
				end else begin
					field_idx = 3'd0;
					if (parse_phase == PH_LEN && announced_len == ESCAPE_LEN) begin
						parse_phase = PH_EXLEN;
						next_need   = 64'(EXLEN_BYTES);
					end else begin
						parse_phase = PH_ID;
						next_need   = 64'(ID_BYTES);
					end
					if (next_need > 64'(max_len_cfg))
						return halt_parse();
				end
			end
		endcase
		return form_result(KIND_HEADER, 8'd0, frame_id, 1'b0, announced_len);
	endfunction

	// Byte sender: record and predict each accepted item, then offer the next one
	// unless this cycle is spent idle. Hold the payload while it is stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte  <= 8'd0;
		end else begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(parse_byte(rx_byte));
				bytes_accepted++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte  <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Result receiver: check each accepted item against the oldest prediction,
	// then decide whether to stall the next cycle.
	always @(posedge clk or negedge arst_n) begin : result_check
		result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				kind_count[kind]++;
				results_checked++;
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result, expected none, actual kind %0d data %0h",
						$time, kind, data);
				end else begin
					want = expected_results.pop_front();
					compare_field("kind", 32'(want.kind), 32'(kind));
					compare_field("data", 32'(want.data), 32'(data));
					compare_field("message_id", 32'(want.message_id), 32'(message_id));
					compare_field("last", 32'(want.last), 32'(last));
					compare_field("payload_length", want.payload_length, payload_length);
				end
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	task automatic push_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
	endtask

	// Queue a frame header: short or escaped extended length, then the id.
	task automatic queue_header(input logic [63:0] len, input logic [15:0] id, input bit ext);
		if (ext) begin
			push_byte(8'hFF);
			push_byte(8'hFF);
			for (int i = 0; i < 8; i++)
				push_byte(len[8*i +: 8]);
		end else begin
			push_byte(len[7:0]);
			push_byte(len[15:8]);
		end
		push_byte(id[7:0]);
		push_byte(id[15:8]);
		frames_queued++;
	endtask

	task automatic queue_payload(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			push_byte(8'($urandom));
	endtask

	// Wait until every queued byte is taken and every predicted result has arrived.
	task automatic drain();
		do @(posedge clk);
		while (pending_bytes.size() != 0 || results_checked < bytes_queued);
	endtask

	// Write the frame size limit; only ever called with the parser idle.
	task automatic set_max_length(input logic [31:0] v);
		drain();
		cfg_valid          <= 1'b1;
		max_request_length <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_len_cfg = v;
		limits_written++;
	endtask

	task automatic set_pace(input int p);
		send_idle_pct = idle_pcts[p];
		stall_pct     = stall_pcts[p];
	endtask

	// One well-formed frame that fits the limit: mostly short payloads, some empty, some
	// filling the limit (capped at 300 bytes), now and then escaped to an extended length.
	task automatic queue_random_frame(input logic [31:0] limit);
		logic [63:0] room;
		logic [63:0] len;
		bit          ext;
		int unsigned roll;
		ext  = (limit >= 32'd12) && ($urandom_range(5) == 0);
		room = 64'(limit) - (ext ? 64'd12 : 64'd4);
		roll = $urandom_range(15);
		if (room == 64'd0 || roll == 0)
			len = 64'd0;
		else if (roll == 1)
			len = (room < 64'd300) ? room : 64'd300;
		else
			len = 64'($urandom_range((room < 64'd24) ? 32'(room) : 24, 1));
		queue_header(len, 16'($urandom), ext);
		// now and then hold the sender mid-frame until the parser has caught up
		if (len != 64'd0 && $urandom_range(30) == 0)
			drain();
		queue_payload(32'(len));
	endtask

	task automatic run_random_phase(input logic [31:0] limit, input int pace, input int budget);
		int unsigned start;
		set_max_length(limit);
		set_pace(pace);
		start = bytes_queued;
		while (bytes_queued - start < budget)
			queue_random_frame(limit);
	endtask

	initial begin
		overflow_case_t how;
		parser_halted = 1'b0;
		max_len_cfg   = MAX_LEN_RESET;
		clear_frame();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset limit: an empty message with an all-ones id,
		// a one-byte payload, and an escaped extended length with a two-byte payload.
		set_pace(0);
		queue_header(64'd0, 16'hFFFF, 1'b0);
		queue_header(64'd1, 16'h0000, 1'b0);
		push_byte(8'hFF);
		queue_header(64'd2, 16'h8001, 1'b1);
		push_byte(8'h00);
		push_byte(8'h80);

		// Random frames under several limits, the smallest and largest among them.
		run_random_phase(32'd4, 1, 250);
		run_random_phase(32'hFFFF_FFFF, 2, 260);
		run_random_phase(32'd12, 3, 250);
		run_random_phase(32'd40, 0, 260);
		run_random_phase(32'($urandom_range(400, 13)), 3, 250);
		run_random_phase(MAX_LEN_RESET, 2, 260);

		// The too-large error is sticky until reset, so raise it last.
		how = overflow_case_t'($urandom_range(4));
		case (how)
			ERR_ANY_BYTE: begin
				set_max_length(32'd0);
				queue_payload(4);
			end
			ERR_ANNOUNCED: begin
				set_max_length(32'd50);
				queue_header(64'($urandom_range(160, 51)), 16'($urandom), 1'b0);
			end
			ERR_EXTENDED: begin
				// length beyond 32 bits: the reported length saturates before the error
				set_max_length(32'hFFFF_FFFF);
				queue_header({8'($urandom_range(255, 1)), 24'($urandom), 32'($urandom)},
					16'($urandom), 1'b1);
			end
			ERR_RUNNING: begin
				// payload fits the limit, header plus payload does not
				set_max_length(32'd20);
				queue_header(64'd17, 16'($urandom), 1'b0);
				queue_payload(17);
			end
			default: begin
				set_max_length(32'd1);
				queue_header(64'd0, 16'($urandom), 1'b0);
			end
		endcase
		queue_payload(6);
		// a new limit must not clear the error
		set_max_length(32'd0);
		queue_header(64'd0, 16'($urandom), 1'b0);

		drain();
		repeat (4) @(posedge clk);
		$display("Summary: %0d bytes in %0d frames, %0d limit writes, overflow case %s",
			bytes_accepted, frames_queued, limits_written, how.name());
		$display("Results: %0d header, %0d payload, %0d empty message, %0d too large",
			kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout: results still outstanding after 2 ms");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/lpfp_pkg.sv
rtl/core/lpfp_core.sv
rtl/core/length_prefixed_frame_parser.sv
tb/sv/tb_length_prefixed_frame_parser.sv
